// ===== rtl/core/sfa_lower_bound_distance_unit_defines.svh =====
// Assertion macros shared by the lower-bound distance unit.
`ifndef SFA_LOWER_BOUND_DISTANCE_UNIT_DEFINES_SVH
`define SFA_LOWER_BOUND_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFA_LBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFA_LBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sfa_lbd_pkg.sv =====
// Package: sizes, register codes and item types of the lower-bound distance unit.
package sfa_lbd_pkg;

  localparam int unsigned SEGMENTS    = 16;
  localparam int unsigned SYMBOL_BITS = 8;
  localparam int unsigned SLOTS       = 1 << SYMBOL_BITS;
  localparam int unsigned SEG_AW      = $clog2(SEGMENTS);
  localparam int unsigned TBL_AW      = SEG_AW + SYMBOL_BITS;
  localparam int unsigned TBL_DEPTH   = SEGMENTS * SLOTS;

  localparam int unsigned Q_W    = 32;
  localparam int unsigned SUM_W  = 63;
  localparam int unsigned CFG_AW = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [2:0] {
    REG_MAX_SYMBOL_BITS = 3'd0,
    REG_ALPHABET_SIZE   = 3'd1,
    REG_FIRST_SPECIAL   = 3'd2,
    REG_LOWER_LIMIT     = 3'd3,
    REG_UPPER_LIMIT     = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         segment;
    logic [7:0]         bin_slot;
    logic signed [31:0] breakpoint_value;
    logic signed [31:0] coeff_value;
    logic [7:0]         symbol;
    logic [3:0]         symbol_bits;
    logic [62:0]        abandon_limit;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [62:0] distance;
    logic        abandoned;
  } out_item_t;

  // Control that rides along the query pipeline.
  typedef struct packed {
    logic             vld;    // query item in this stage
    logic             add;    // segment contributes a term
    logic             half;   // weight one instead of two
    logic             last;
    logic [SUM_W-1:0] limit;
  } pipe_ctl_t;

endpackage

// ===== rtl/core/sfa_lbd_in_if.sv =====
// Input item channel: valid/ready handshake with the query/load payload.
interface sfa_lbd_in_if;
  import sfa_lbd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sfa_lbd_out_if.sv =====
// Result item channel: valid/ready handshake with distance and abandoned flag.
interface sfa_lbd_out_if;
  import sfa_lbd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sfa_lower_bound_distance_unit.sv =====
// Lower-bound distance unit: breakpoint table, four-stage query pipe, accumulator.
// Throughput: one item per cycle unless the pipe stalls on an unclaimed result;
//   set by the breakpoint memory (one write, two read ports) and the saturating add loop.
// Path: a query with last set moves through s1_r, s2_r and s3_r into the output register.
// Reset (rst_n, synchronous): sum, flag, pipe valids, output valid and config registers
//   return to defaults; the breakpoint table is not cleared and holds garbage until loaded.
module sfa_lower_bound_distance_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  sfa_lbd_in_if.sink                    in_item,
  sfa_lbd_out_if.source                 out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfa_lbd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sfa_lbd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers (APB, zero wait states)
  // ---------------------------------------------------------------------------
  logic [3:0]         max_bits_r;
  logic [8:0]         alphabet_r;
  logic               special_r;
  logic signed [31:0] lower_lim_r;
  logic signed [31:0] upper_lim_r;

  logic     cfg_wr;
  cfg_reg_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bits_r  <= 4'd8;
      alphabet_r  <= 9'd256;
      special_r   <= 1'b0;
      lower_lim_r <= 32'sh8000_0000;
      upper_lim_r <= 32'sh7FFF_FFFF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAX_SYMBOL_BITS: max_bits_r  <= pwdata[3:0];
        REG_ALPHABET_SIZE:   alphabet_r  <= pwdata[8:0];
        REG_FIRST_SPECIAL:   special_r   <= pwdata[0];
        REG_LOWER_LIMIT:     lower_lim_r <= pwdata;
        REG_UPPER_LIMIT:     upper_lim_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MAX_SYMBOL_BITS: prdata = {28'd0, max_bits_r};
      REG_ALPHABET_SIZE:   prdata = {23'd0, alphabet_r};
      REG_FIRST_SPECIAL:   prdata = {31'd0, special_r};
      REG_LOWER_LIMIT:     prdata = lower_lim_r;
      REG_UPPER_LIMIT:     prdata = upper_lim_r;
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipe moves together. It stops only when a last
  // item reaches the accumulator while the previous result is still unclaimed.
  // ---------------------------------------------------------------------------
  pipe_ctl_t  s1_r, s2_r, s3_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       advance;
  logic       in_fire;
  logic       acc_fire;

  assign advance  = !(out_valid_r && !out_item.ready && s3_r.vld && s3_r.last);
  assign in_item.ready = advance;
  assign in_fire  = in_item.valid && advance;
  assign acc_fire = s3_r.vld && advance;

  // ---------------------------------------------------------------------------
  // Stage 0: widen symbol to a region range, form table addresses.
  // ---------------------------------------------------------------------------
  in_item_t             it;
  logic [3:0]           shift;
  logic [SYMBOL_BITS-1:0] rlo, rhi;
  logic [8:0]           top;
  logic                 seg_ok;
  logic                 slot_ok;
  logic                 is_query;
  logic [SEG_AW-1:0]    seg_idx;
  logic [TBL_AW-1:0]    ra_lo, ra_hi, wa;
  logic                 tbl_we;
  logic                 lo_lim_sel, hi_lim_sel;
  pipe_ctl_t            s0_ctl;

  assign it = in_item.data;

  always_comb begin
    shift = (it.symbol_bits > max_bits_r) ? 4'd0 : max_bits_r - it.symbol_bits;
    if (32'(shift) >= SYMBOL_BITS) begin
      rlo = '0;
      rhi = '1;
    end else begin
      rlo = SYMBOL_BITS'(it.symbol) << shift;
      rhi = rlo | ~({SYMBOL_BITS{1'b1}} << shift);
    end
    top        = (alphabet_r == 9'd0) ? 9'd0 : alphabet_r - 9'd1;
    lo_lim_sel = (rlo == '0);
    hi_lim_sel = (9'(rhi) >= top);

    seg_ok   = (32'(it.segment) < SEGMENTS);
    slot_ok  = (32'(it.bin_slot) < SLOTS);
    is_query = (opcode_t'(it.opcode) == OP_QUERY);
    seg_idx  = SEG_AW'(it.segment);
    ra_lo    = {seg_idx, rlo - SYMBOL_BITS'(1)};
    ra_hi    = {seg_idx, rhi};
    wa       = {seg_idx, SYMBOL_BITS'(it.bin_slot)};
    tbl_we   = in_fire && !is_query && seg_ok && slot_ok;

    s0_ctl.vld   = in_fire && is_query;
    s0_ctl.add   = seg_ok && !(special_r && it.segment == 4'd1);
    s0_ctl.half  = special_r && it.segment == 4'd0;
    s0_ctl.last  = it.last;
    s0_ctl.limit = it.abandon_limit;
  end

  // Breakpoint table. Write and reads happen at the accept edge, so a load
  // is visible to a query accepted on the very next cycle.
  logic [Q_W-1:0] tbl_mem [TBL_DEPTH];
  logic [Q_W-1:0] rd_lo_r, rd_hi_r;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[wa] <= it.breakpoint_value;
    end
    if (advance) begin
      rd_lo_r <= tbl_mem[ra_lo];
      rd_hi_r <= tbl_mem[ra_hi];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 payload: coefficient and limit-select flags.
  // ---------------------------------------------------------------------------
  logic signed [31:0] s1_coeff_r;
  logic               s1_lo_lim_r, s1_hi_lim_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_coeff_r  <= it.coeff_value;
      s1_lo_lim_r <= lo_lim_sel;
      s1_hi_lim_r <= hi_lim_sel;
    end
  end

  // Stage 1 -> 2: pick breakpoints, distance outside [lower, upper].
  logic signed [31:0] blo, bhi;
  logic signed [32:0] diff_lo, diff_hi;
  logic [31:0]        excess;

  always_comb begin
    blo     = s1_lo_lim_r ? lower_lim_r : $signed(rd_lo_r);
    bhi     = s1_hi_lim_r ? upper_lim_r : $signed(rd_hi_r);
    diff_lo = {blo[31], blo} - {s1_coeff_r[31], s1_coeff_r};
    diff_hi = {s1_coeff_r[31], s1_coeff_r} - {bhi[31], bhi};
    if (blo > s1_coeff_r) begin
      excess = diff_lo[31:0];
    end else if (bhi < s1_coeff_r) begin
      excess = diff_hi[31:0];
    end else begin
      excess = 32'd0;
    end
  end

  logic [31:0] s2_dist_r;
  logic [63:0] s3_sq_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_dist_r <= excess;
      s3_sq_r   <= s2_dist_r * s2_dist_r;   // exact Q32.32 square
    end
  end

  // Pipe control valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else if (advance) begin
      s1_r <= s0_ctl;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate: weight, saturating add, abandon check. Frozen once abandoned.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             flag_r, flag_nxt;
  logic [SUM_W-1:0] term;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_cand;

  always_comb begin
    if (s3_r.half) begin
      term = s3_sq_r[63] ? SUM_MAX : s3_sq_r[SUM_W-1:0];
    end else begin
      term = (s3_sq_r[63] || s3_sq_r[62]) ? SUM_MAX : {s3_sq_r[61:0], 1'b0};
    end
    sum_wide = {1'b0, sum_r} + {1'b0, term};
    sum_cand = !s3_r.add ? sum_r : (sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0]);
    if (flag_r) begin
      sum_nxt  = sum_r;
      flag_nxt = 1'b1;
    end else begin
      sum_nxt  = sum_cand;
      flag_nxt = (sum_cand > s3_r.limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_fire) begin
        if (s3_r.last) begin
          sum_r  <= '0;
          flag_r <= 1'b0;
        end else begin
          sum_r  <= sum_nxt;
          flag_r <= flag_nxt;
        end
      end
      if (acc_fire && s3_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire && s3_r.last) begin
      out_data_r.distance  <= sum_nxt;
      out_data_r.abandoned <= flag_nxt;
    end
  end

  assign out_item.valid = out_valid_r;
  assign out_item.data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "sfa_lower_bound_distance_unit_defines.svh"

  `SFA_LBD_ASSERT_NEXT(a_clear_after_last, acc_fire && s3_r.last, sum_r == '0 && !flag_r, "sum not cleared after last item")
  `SFA_LBD_ASSERT_NEXT(a_flag_sticky, flag_r && !(acc_fire && s3_r.last), flag_r && $stable(sum_r), "abandoned sum not frozen")
  `SFA_LBD_ASSERT_NOW(a_flag_needs_sum, flag_r, sum_r != '0, "abandon flag set with zero sum")

endmodule

// ===== verif/sfa_lower_bound_distance_unit_tb.sv =====
// Self-checking testbench of the SFA lower-bound distance unit.
`timescale 1ns / 100ps

module sfa_lower_bound_distance_unit_tb;
  import sfa_lbd_pkg::*;

  // Watchdog bound; it leaves ample margin over the slowest legal run.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Extra cycles to let the pipe settle before touching registers or ending.
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam logic [63:0]        SUM_CAP = {1'b0, SUM_MAX};
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  sfa_lbd_in_if  in_ch ();
  sfa_lbd_out_if out_ch ();

  sfa_lower_bound_distance_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Register shadow: written only by the stimulus, and only while the unit idles.
  // ---------------------------------------------------------------------------
  logic [3:0]         cfg_msb     = 4'd8;
  logic [8:0]         cfg_alpha   = 9'd256;
  logic               cfg_special = 1'b0;
  logic signed [31:0] cfg_lower   = Q_MIN;
  logic signed [31:0] cfg_upper   = Q_MAX;

  // Predicted datapath state.
  logic signed [31:0] bp_shadow [TBL_DEPTH];
  logic [63:0]        acc_sum    = '0;
  logic               acc_frozen = 1'b0;
  out_item_t          due_distances [$];

  // Stimulus side.
  in_item_t    item_backlog [$];
  bit          bp_loaded [TBL_DEPTH];   // entries that some queued load has written
  int unsigned gen_count     = 0;
  int unsigned items_taken   = 0;
  int unsigned loads_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned settings_done = 0;
  int unsigned errors        = 0;
  int unsigned cycle_count   = 0;

  // Sender burst shaping.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  // Receiver stall pattern; hold_req asks for one long hold-off.
  bit          hold_req   = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned rx_mode    = 0;
  int unsigned rx_tick    = 0;
  out_item_t   result_want;

  // ---------------------------------------------------------------------------
  // Distance prediction
  // ---------------------------------------------------------------------------

  // Range of full-resolution regions that a coarse symbol stands for.
  function automatic void symbol_region(input logic [7:0] sym, input logic [3:0] bits,
                                        output logic [7:0] rlo, output logic [7:0] rhi);
    int unsigned shift;
    shift = (bits > cfg_msb) ? 0 : cfg_msb - bits;
    if (shift >= SYMBOL_BITS) begin
      rlo = '0;
      rhi = '1;
    end else begin
      rlo = sym << shift;
      rhi = rlo | ((8'd1 << shift) - 8'd1);
    end
  endfunction

  function automatic int unsigned top_region();
    return (cfg_alpha == 0) ? 0 : cfg_alpha - 1;
  endfunction

  // Squared Q32.32 distance of a coefficient outside its symbol's region.
  function automatic logic [63:0] outside_square(logic [3:0] seg, logic signed [31:0] coeff,
                                                 logic [7:0] sym, logic [3:0] bits);
    logic [7:0]  rlo;
    logic [7:0]  rhi;
    longint      blo;
    longint      bhi;
    longint      c;
    longint      d;
    logic [63:0] du;
    symbol_region(sym, bits, rlo, rhi);
    // bottom region is bounded by the lower limit, the top one by the upper limit
    blo = (rlo == 0) ? longint'(cfg_lower) : longint'(bp_shadow[{seg, rlo - 8'd1}]);
    bhi = (rhi >= top_region()) ? longint'(cfg_upper) : longint'(bp_shadow[{seg, rhi}]);
    c = coeff;
    d = 0;
    if (blo > c) d = blo - c;
    else if (bhi < c) d = c - bhi;
    du = d;
    return du * du;
  endfunction

  // Applies one accepted item; a query with last set queues its distance.
  function automatic void advance_distance(in_item_t it);
    logic [63:0] sq;
    logic [63:0] term;
    if (it.opcode == OP_LOAD) begin
      bp_shadow[{it.segment, it.bin_slot}] = it.breakpoint_value;
    end else begin
      if (!acc_frozen) begin
        // special mode: DC term weighs one, segment 1 drops out
        if (!(cfg_special && it.segment == 4'd1)) begin
          sq = outside_square(it.segment, it.coeff_value, it.symbol, it.symbol_bits);
          if (cfg_special && it.segment == 4'd0)
            term = (sq > SUM_CAP) ? SUM_CAP : sq;
          else
            term = (sq > (SUM_CAP >> 1)) ? SUM_CAP : sq << 1;
          acc_sum = (term > SUM_CAP - acc_sum) ? SUM_CAP : acc_sum + term;
        end
        if (acc_sum > {1'b0, it.abandon_limit}) acc_frozen = 1'b1;
      end
      if (it.last) begin
        due_distances.push_back('{distance: acc_sum[62:0], abandoned: acc_frozen});
        acc_sum    = '0;
        acc_frozen = 1'b0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------

  // Q16.16 value: mostly near the origin so region hits happen, some extremes.
  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return ($urandom_range(0, 1) != 0) ? Q_MIN : Q_MAX;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic [62:0] rand_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return SUM_MAX;
      2:       return 63'({$urandom, $urandom});
      default: return 63'($urandom) << $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [3:0] rand_bits();
    int unsigned cap;
    cap = (cfg_msb > SYMBOL_BITS) ? SYMBOL_BITS : cfg_msb;
    case ($urandom_range(0, 7))
      0:       return 4'($urandom_range(0, 15));
      1:       return 4'd0;
      default: return 4'($urandom_range(0, cap));
    endcase
  endfunction

  function automatic logic [7:0] rand_sym(logic [3:0] bits);
    if (bits >= SYMBOL_BITS || $urandom_range(0, 5) == 0) return 8'($urandom);
    return 8'($urandom_range(0, (1 << bits) - 1));
  endfunction

  // Query fields of a load are don't-care; fill them with noise.
  function automatic void push_load(logic [3:0] seg, logic [7:0] slot, logic signed [31:0] val);
    in_item_t it;
    it                  = '0;
    it.opcode           = OP_LOAD;
    it.segment          = seg;
    it.bin_slot         = slot;
    it.breakpoint_value = val;
    it.coeff_value      = $urandom;
    it.symbol           = 8'($urandom);
    it.symbol_bits      = 4'($urandom);
    it.abandon_limit    = 63'({$urandom, $urandom});
    it.last             = 1'($urandom);
    item_backlog.push_back(it);
    bp_loaded[{seg, slot}] = 1'b1;
    gen_count++;
  endfunction

  // Breakpoints the query will read are loaded first if nothing wrote them yet.
  function automatic void push_query(logic [3:0] seg, logic signed [31:0] coeff, logic [7:0] sym,
                                     logic [3:0] bits, logic [62:0] lim, logic last);
    logic [7:0] rlo;
    logic [7:0] rhi;
    in_item_t   it;
    symbol_region(sym, bits, rlo, rhi);
    if (rlo != 0 && !bp_loaded[{seg, rlo - 8'd1}]) push_load(seg, rlo - 8'd1, rand_q());
    if (rhi < top_region() && !bp_loaded[{seg, rhi}]) push_load(seg, rhi, rand_q());
    it                  = '0;
    it.opcode           = OP_QUERY;
    it.segment          = seg;
    it.bin_slot         = 8'($urandom);
    it.breakpoint_value = $urandom;
    it.coeff_value      = coeff;
    it.symbol           = sym;
    it.symbol_bits      = bits;
    it.abandon_limit    = lim;
    it.last             = last;
    item_backlog.push_back(it);
    gen_count++;
  endfunction

  // A word: segments in order, last on the final one, limit may change midway.
  // A broken word scatters segments, never closes and runs into what follows.
  function automatic void push_word(bit broken);
    int unsigned nseg;
    int unsigned s;
    logic [62:0] lim;
    logic [3:0]  seg;
    logic [3:0]  bits;
    nseg = $urandom_range(1, SEGMENTS);
    lim  = rand_limit();
    for (s = 0; s < nseg; s++) begin
      if ($urandom_range(0, 11) == 0) push_load(4'($urandom), 8'($urandom), rand_q());
      if ($urandom_range(0, 9) == 0) lim = rand_limit();
      seg  = broken ? 4'($urandom) : 4'(s);
      bits = rand_bits();
      push_query(seg, rand_q(), rand_sym(bits), bits, lim, !broken && s == nseg - 1);
    end
  endfunction

  function automatic void fill_backlog(int unsigned budget);
    int unsigned start;
    logic [3:0]  bits;
    start = gen_count;
    while (gen_count - start < budget) begin
      case ($urandom_range(0, 9))
        7: repeat ($urandom_range(1, 4)) begin
          bits = rand_bits();
          push_query(4'($urandom), rand_q(), rand_sym(bits), bits, rand_limit(),
                     $urandom_range(0, 2) == 0);
        end
        8: repeat ($urandom_range(1, 6)) push_load(4'($urandom), 8'($urandom), rand_q());
        9:       push_word(1'b1);
        default: push_word(1'b0);
      endcase
    end
    // close any open word so the sum is clear before registers change
    push_query(4'($urandom), rand_q(), 8'd0, 4'd0, rand_limit(), 1'b1);
  endfunction

  // Extremes under reset settings: saturation, abandon and freeze, coarse and
  // over-resolved symbols, both limit registers, slot 255.
  function automatic void push_directed();
    push_load(4'd0, 8'd0, Q_MIN);
    push_load(4'd15, 8'd255, Q_MAX);
    push_load(4'd1, 8'd254, Q_ONE);
    push_load(4'd2, 8'd127, -Q_ONE);
    push_load(4'd2, 8'd128, Q_ONE);
    // full-scale difference: term saturates, then the sum stays at the cap
    push_query(4'd0, Q_MAX, 8'd0, 4'd8, SUM_MAX, 1'b0);
    push_query(4'd1, Q_MIN, 8'd255, 4'd8, SUM_MAX, 1'b1);
    // inside the region adds nothing; then a miss crosses a zero limit
    push_query(4'd2, 32'sd0, 8'd128, 4'd8, '0, 1'b0);
    push_query(4'd2, 3 * Q_ONE, 8'd128, 4'd8, '0, 1'b0);
    // frozen: this one must not add
    push_query(4'd3, Q_MAX, 8'd0, 4'd0, '0, 1'b1);
    // more symbol bits than configured, and a 4-bit symbol widened to the top
    push_query(4'd4, 32'sd0, 8'hFF, 4'd15, SUM_MAX, 1'b0);
    push_query(4'd15, Q_MIN, 8'h0F, 4'd4, SUM_MAX, 1'b1);
    // lone last item with zero-resolution symbol
    push_query(4'd7, Q_MAX, 8'd0, 4'd0, SUM_MAX, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] msb, input logic [8:0] alpha,
                            input logic special, input logic signed [31:0] lo,
                            input logic signed [31:0] hi);
    write_reg(REG_MAX_SYMBOL_BITS, 32'(msb));
    write_reg(REG_ALPHABET_SIZE, 32'(alpha));
    write_reg(REG_FIRST_SPECIAL, 32'(special));
    write_reg(REG_LOWER_LIMIT, lo);
    write_reg(REG_UPPER_LIMIT, hi);
    cfg_msb     = msb;
    cfg_alpha   = alpha;
    cfg_special = special;
    cfg_lower   = lo;
    cfg_upper   = hi;
    settings_done++;
  endtask

  // Everything queued has gone in and every distance has come back; then let
  // the pipe settle past its latency.
  task automatic wait_idle();
    while (items_taken != gen_count || due_distances.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned budget, bit long_hold);
    fill_backlog(budget);
    if (long_hold) hold_req = 1'b1;
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_distance(in_ch.data);
        items_taken++;
        if (in_ch.data.opcode == OP_LOAD) loads_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          in_ch.data  <= item_backlog.pop_front();
          in_ch.valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall mode changes at random; one long hold-off on
  // request. Each accepted result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (due_distances.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: expected none, got distance %h abandoned %b",
                   $time, out_ch.data.distance, out_ch.data.abandoned);
        end else begin
          result_want = due_distances.pop_front();
          if (out_ch.data.distance !== result_want.distance) begin
            errors++;
            $display("%0t: distance mismatch: expected %h, got %h",
                     $time, result_want.distance, out_ch.data.distance);
          end
          if (out_ch.data.abandoned !== result_want.abandoned) begin
            errors++;
            $display("%0t: abandoned mismatch: expected %b, got %b",
                     $time, result_want.abandoned, out_ch.data.abandoned);
          end
        end
      end

      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (rx_tick == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_tick = $urandom_range(20, 80);
      end else begin
        rx_tick--;
      end

      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (rx_tick % 3 != 0);
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d items in, %0d distances still due",
               $time, items_taken, due_distances.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items, then random phases under several settings.
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings
    push_directed();
    run_phase(150, 1'b0);
    // special first coefficient, narrow limits
    set_config(4'd8, 9'd256, 1'b1, -4 * Q_ONE, 4 * Q_ONE);
    run_phase(180, 1'b0);
    // coarse alphabet; receiver holds off so the pipe backs up
    set_config(4'd4, 9'd16, 1'b0, Q_MIN, Q_MAX);
    run_phase(180, 1'b1);
    // smallest legal setting
    set_config(4'd1, 9'd2, 1'b1, 32'sd0, 32'sd0);
    run_phase(150, 1'b0);
    // register maxima: shift past the symbol width, alphabet past the table
    set_config(4'd15, 9'd511, 1'b0, -Q_ONE, Q_ONE);
    run_phase(150, 1'b0);
    // tiny alphabet, zero bits, inverted limits
    set_config(4'd0, 9'd0, 1'b1, Q_MAX, Q_MIN);
    run_phase(120, 1'b0);
    set_config(4'd8, 9'd1, 1'b0, rand_q(), rand_q());
    run_phase(120, 1'b0);
    repeat (3) begin
      set_config(4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)),
                 1'($urandom_range(0, 1)), rand_q(), rand_q());
      run_phase(120, 1'b0);
    end

    $display("covered %0d items (%0d breakpoint loads) over %0d register settings",
             items_taken, loads_taken, settings_done);
    $display("checked %0d distance results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
